[rtl/bmw_pkg.sv]
// Shared types and constants for the block map walker.
package bmw_pkg;

    localparam logic [3:0]  SLOT_SINGLE = 4'd12;
    localparam logic [3:0]  SLOT_DOUBLE = 4'd13;
    localparam logic [3:0]  SLOT_TRIPLE = 4'd14;
    localparam logic [3:0]  SLOT_SIZE   = 4'd15;
    localparam logic [31:0] NO_BLOCK    = 32'hFFFF_FFFF;
    localparam logic [3:0]  LOG2_MIN    = 4'd8;
    localparam logic [3:0]  LOG2_MAX    = 4'd14;

    localparam logic RK_READ = 1'b0;
    localparam logic RK_DONE = 1'b1;

    localparam logic CFG_LOG2 = 1'b0;
    localparam logic CFG_MAX  = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_XLATE = 2'd1,
        KIND_RESP  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EOF   = 2'd1,
        ST_LIMIT = 2'd2,
        ST_BUSY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CLS_DIRECT,
        CLS_SINGLE,
        CLS_DOUBLE,
        CLS_TRIPLE,
        CLS_BEYOND
    } t_cls;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  inode_slot;
        logic [31:0] data_word;
        logic [31:0] logical_block;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] read_block;
        logic [13:0] read_index;
        logic [31:0] physical_block;
        logic [1:0]  status;
    } t_out;

    // second stage: decoded beat plus inode words read for it
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] word;
        t_cls        cls;
        logic        over_limit;
        logic        eof_ovf;
        logic [31:0] eof_lo;
        logic [13:0] first_idx;
        logic [27:0] resid;
        logic [31:0] size;
        logic [31:0] ptr;
    } t_s1;

endpackage

[rtl/block_map_walker_top.sv]
// Top level of the block map walker: config registers, handshake, result register.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------
//  input    | in  | i_valid / o_stall     | i_data  (t_in)
//  result   | out | o_valid / i_stall     | o_data  (t_out)
//  config   | in  | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One beat per clock while o_stall is low; a result passes the stage-0 registers
// and then the result register. Stage 0 registers the beat and reads the inode memory,
// stage 1 updates walk state and loads the result register.
// i_stall holds the result register; o_stall rises only when stage 1 is full and
// cannot move. Synchronous active-low reset clears valids and walk state; the
// inode memory is not cleared, every inode word must be loaded before use.
module block_map_walker_top import bmw_pkg::*; #(
    parameter int DIRECT_POINTERS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [3:0]  r_log2;
    logic [31:0] r_max;
    logic [3:0]  eff_log2;

    t_s1         s1;
    t_out        res;
    logic        has_res;
    logic        accept;
    logic        fire;

    logic        r_out_valid, n_out_valid;
    t_out        r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= LOG2_MIN;
            r_max  <= NO_BLOCK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOG2: r_log2 <= i_cfg_data[3:0];
                CFG_MAX:  r_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // log2 of pointers per block clamped to the supported range
    always_comb begin
        if (r_log2 < LOG2_MIN) begin
            eff_log2 = LOG2_MIN;
        end else if (r_log2 > LOG2_MAX) begin
            eff_log2 = LOG2_MAX;
        end else begin
            eff_log2 = r_log2;
        end
    end

    // stage 1 moves when the result register is free or being drained
    assign fire    = s1.valid && (!r_out_valid || !i_stall);
    assign o_stall = s1.valid && !fire;
    assign accept  = i_valid && !o_stall;

    bmw_front #(
        .DIRECT_POINTERS (DIRECT_POINTERS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_fire   (fire),
        .i_item   (i_data),
        .i_log2   (eff_log2),
        .i_max    (r_max),
        .o_s1     (s1)
    );

    bmw_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_s1    (s1),
        .i_log2  (eff_log2),
        .o_res   (res),
        .o_has   (has_res)
    );

    // result register
    always_comb begin
        if (fire && has_res) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_res) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/bmw_front.sv]
// Front stage: inode word memory, range classification and index split.
module bmw_front import bmw_pkg::*; #(
    parameter int DIRECT_POINTERS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_fire,
    input  t_in         i_item,
    input  logic [3:0]  i_log2,
    input  logic [31:0] i_max,
    output t_s1         o_s1
);

    logic [31:0] r_mem [16];

    logic        r_valid;
    t_kind       r_kind;
    logic [31:0] r_word;
    t_cls        r_cls;
    logic        r_over_limit;
    logic        r_eof_ovf;
    logic [31:0] r_eof_lo;
    logic [13:0] r_first_idx;
    logic [27:0] r_resid;
    logic [31:0] r_size;
    logic [31:0] r_ptr;

    logic [31:0] lbn;
    logic [31:0] d1, d2, d3;
    logic [4:0]  p2;
    logic [5:0]  p3;
    logic [47:0] bytes_off;
    t_cls        cls;
    logic [3:0]  slot_b;
    logic [13:0] first_idx;
    logic [27:0] resid;
    logic [31:0] mask1, mask2;

    always_comb begin
        lbn       = i_item.logical_block;
        p2        = {i_log2, 1'b0};
        p3        = {2'b00, i_log2} + {1'b0, p2};
        d1        = lbn - 32'(DIRECT_POINTERS);
        d2        = d1 - (32'd1 << i_log2);
        d3        = d2 - (32'd1 << p2);
        mask1     = (32'd1 << i_log2) - 32'd1;
        mask2     = (32'd1 << p2) - 32'd1;
        bytes_off = {16'd0, lbn} << (5'(i_log2) + 5'd2);

        if (lbn < 32'(DIRECT_POINTERS)) begin
            cls = CLS_DIRECT;
        end else if ((d1 >> i_log2) == 32'd0) begin
            cls = CLS_SINGLE;
        end else if ((d2 >> p2) == 32'd0) begin
            cls = CLS_DOUBLE;
        end else if ((d3 >> p3) == 32'd0) begin
            cls = CLS_TRIPLE;
        end else begin
            cls = CLS_BEYOND;
        end

        case (cls)
            CLS_DIRECT: begin
                slot_b    = lbn[3:0];
                first_idx = '0;
                resid     = '0;
            end
            CLS_SINGLE: begin
                slot_b    = SLOT_SINGLE;
                first_idx = d1[13:0];
                resid     = '0;
            end
            CLS_DOUBLE: begin
                slot_b    = SLOT_DOUBLE;
                first_idx = 14'(d2 >> i_log2);
                resid     = 28'(d2 & mask1);
            end
            CLS_TRIPLE: begin
                slot_b    = SLOT_TRIPLE;
                first_idx = 14'(d3 >> p2);
                resid     = 28'(d3 & mask2);
            end
            default: begin
                slot_b    = SLOT_TRIPLE;
                first_idx = '0;
                resid     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && t_kind'(i_item.kind) == KIND_LOAD) begin
            r_mem[i_item.inode_slot] <= i_item.data_word;
        end
        if (i_accept) begin
            r_size <= r_mem[SLOT_SIZE];
            r_ptr  <= r_mem[slot_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind       <= t_kind'(i_item.kind);
            r_word       <= i_item.data_word;
            r_cls        <= cls;
            r_over_limit <= lbn > i_max;
            r_eof_ovf    <= |bytes_off[47:32];
            r_eof_lo     <= bytes_off[31:0];
            r_first_idx  <= first_idx;
            r_resid      <= resid;
        end
    end

    always_comb begin
        o_s1.valid      = r_valid;
        o_s1.kind       = r_kind;
        o_s1.word       = r_word;
        o_s1.cls        = r_cls;
        o_s1.over_limit = r_over_limit;
        o_s1.eof_ovf    = r_eof_ovf;
        o_s1.eof_lo     = r_eof_lo;
        o_s1.first_idx  = r_first_idx;
        o_s1.resid      = r_resid;
        o_s1.size       = r_size;
        o_s1.ptr        = r_ptr;
    end

endmodule

[rtl/bmw_walk.sv]
// Walk stage: busy/level/residual state and result formation, in beat order.
module bmw_walk import bmw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_s1        i_s1,
    input  logic [3:0] i_log2,
    output t_out       o_res,
    output logic       o_has
);

    logic        r_busy, n_busy;
    logic [1:0]  r_level, n_level;
    logic [27:0] r_resid, n_resid;
    logic [27:0] mask;

    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_resid = r_resid;
        o_res   = '0;
        o_has   = 1'b0;
        mask    = 28'((32'd1 << i_log2) - 32'd1);

        if (i_s1.valid) begin
            case (i_s1.kind)
                KIND_XLATE: begin
                    o_has             = 1'b1;
                    o_res.result_kind = RK_DONE;
                    if (r_busy) begin
                        o_res.status = ST_BUSY;
                    end else if (i_s1.over_limit) begin
                        o_res.physical_block = NO_BLOCK;
                        o_res.status         = ST_LIMIT;
                    end else if (i_s1.eof_ovf || i_s1.eof_lo >= i_s1.size) begin
                        o_res.status = ST_EOF;
                    end else begin
                        case (i_s1.cls)
                            CLS_DIRECT: begin
                                o_res.physical_block = i_s1.ptr;
                            end
                            CLS_SINGLE, CLS_DOUBLE, CLS_TRIPLE: begin
                                o_res.result_kind = RK_READ;
                                o_res.read_block  = i_s1.ptr;
                                o_res.read_index  = i_s1.first_idx;
                                n_busy            = 1'b1;
                                n_resid           = i_s1.resid;
                                n_level = (i_s1.cls == CLS_SINGLE) ? 2'd0 :
                                          (i_s1.cls == CLS_DOUBLE) ? 2'd1 : 2'd2;
                            end
                            default: begin
                                o_res.physical_block = NO_BLOCK;
                                o_res.status         = ST_LIMIT;
                            end
                        endcase
                    end
                end
                KIND_RESP: begin
                    if (r_busy) begin
                        o_has = 1'b1;
                        if (r_level == 2'd0) begin
                            o_res.result_kind    = RK_DONE;
                            o_res.physical_block = i_s1.word;
                            n_busy               = 1'b0;
                            n_resid              = '0;
                        end else begin
                            o_res.result_kind = RK_READ;
                            o_res.read_block  = i_s1.word;
                            o_res.read_index  = (r_level == 2'd2) ?
                                                14'((r_resid >> i_log2) & mask) :
                                                14'(r_resid & mask);
                            n_level           = r_level - 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= 2'd0;
            r_resid <= '0;
        end else if (i_fire) begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_resid <= n_resid;
        end
    end

    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_level == 2'd0)
        else $error("walk idle with nonzero level");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level != 2'd3)
        else $error("walk level out of range");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_has && o_res.result_kind == RK_READ) |=> r_busy)
        else $error("read request issued without walk pending");

endmodule

[tb/block_map_walker_checker.sv]
// Checker for the block map walker: tracks the inode map and walk, compares result beats.
module block_map_walker_checker import bmw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECT = 12;

    logic [31:0] map_words [16];
    logic [1:0]  levels_left;
    logic [31:0] index_rest;
    logic        walking;
    logic [3:0]  ptr_log2;
    logic [31:0] lbn_limit;

    t_out walk_results_due [$];
    int   err_cnt;
    int   chk_cnt;

    function automatic t_out answer(logic rk, logic [31:0] blk, logic [63:0] idx,
                                    logic [31:0] phys, t_status st);
        t_out a;
        a.result_kind    = rk;
        a.read_block     = blk;
        a.read_index     = idx[13:0];
        a.physical_block = phys;
        a.status         = st;
        return a;
    endfunction

    // one accepted input beat against the tracked map and walk state
    task automatic advance_block_map(input t_in b);
        int unsigned p;
        logic [63:0] ptrs;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] r3;
        logic [63:0] mask;
        logic [63:0] idx;
        p = (ptr_log2 < LOG2_MIN) ? LOG2_MIN : (ptr_log2 > LOG2_MAX) ? LOG2_MAX : ptr_log2;
        ptrs = 64'd1 << p;
        r1 = {32'd0, b.logical_block} - N_DIRECT;
        r2 = r1 - ptrs;
        r3 = r2 - ptrs * ptrs;
        case (t_kind'(b.kind))
            KIND_LOAD: map_words[b.inode_slot] = b.data_word;
            KIND_XLATE: begin
                if (walking)
                    walk_results_due.push_back(answer(RK_DONE, 0, 0, 0, ST_BUSY));
                else if (b.logical_block > lbn_limit)
                    walk_results_due.push_back(answer(RK_DONE, 0, 0, NO_BLOCK, ST_LIMIT));
                else if ({32'd0, b.logical_block} * (ptrs << 2) >= {32'd0, map_words[SLOT_SIZE]})
                    walk_results_due.push_back(answer(RK_DONE, 0, 0, 0, ST_EOF));
                else if (b.logical_block < N_DIRECT)
                    walk_results_due.push_back(answer(RK_DONE, 0, 0,
                                               map_words[b.logical_block[3:0]], ST_OK));
                else if (r1 < ptrs) begin
                    walking = 1'b1;
                    levels_left = 2'd0;
                    index_rest = '0;
                    walk_results_due.push_back(answer(RK_READ, map_words[SLOT_SINGLE], r1,
                                               0, ST_OK));
                end else if (r2 < ptrs * ptrs) begin
                    walking = 1'b1;
                    levels_left = 2'd1;
                    index_rest = 32'(r2 & (ptrs - 1));
                    walk_results_due.push_back(answer(RK_READ, map_words[SLOT_DOUBLE], r2 >> p,
                                               0, ST_OK));
                end else if (r3 < ptrs * ptrs * ptrs) begin
                    walking = 1'b1;
                    levels_left = 2'd2;
                    index_rest = 32'(r3 & (ptrs * ptrs - 1));
                    walk_results_due.push_back(answer(RK_READ, map_words[SLOT_TRIPLE],
                                               r3 >> (2 * p), 0, ST_OK));
                end else
                    walk_results_due.push_back(answer(RK_DONE, 0, 0, NO_BLOCK, ST_LIMIT));
            end
            KIND_RESP: begin
                if (walking) begin
                    if (levels_left == 2'd0) begin
                        walking = 1'b0;
                        index_rest = '0;
                        walk_results_due.push_back(answer(RK_DONE, 0, 0, b.data_word, ST_OK));
                    end else begin
                        mask = ptrs - 1;
                        idx = (levels_left >= 2'd2) ? ({32'd0, index_rest} >> p) & mask
                                                    : {32'd0, index_rest} & mask;
                        levels_left = levels_left - 2'd1;
                        walk_results_due.push_back(answer(RK_READ, b.data_word, idx, 0, ST_OK));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            levels_left = '0;
            index_rest  = '0;
            walking     = 1'b0;
            ptr_log2    = LOG2_MIN;
            lbn_limit   = NO_BLOCK;
            walk_results_due.delete();
            err_cnt = 0;
            chk_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LOG2)
                    ptr_log2 = i_cfg_data[3:0];
                else
                    lbn_limit = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (walk_results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, i_out_data);
                    err_cnt++;
                end else begin
                    want = walk_results_due.pop_front();
                    check_field("result_kind", want.result_kind, i_out_data.result_kind);
                    check_field("read_block", want.read_block, i_out_data.read_block);
                    check_field("read_index", want.read_index, i_out_data.read_index);
                    check_field("physical_block", want.physical_block,
                                i_out_data.physical_block);
                    check_field("status", want.status, i_out_data.status);
                    chk_cnt++;
                end
            end
            if (i_in_valid && !i_in_stall)
                advance_block_map(i_in_data);
        end
        o_errors  <= err_cnt;
        o_pending <= walk_results_due.size();
        o_checked <= chk_cnt;
    end

endmodule

[tb/tb_block_map_walker_top.sv]
// Testbench top for the block map walker: clock, reset, stimulus, stall patterns, verdict.
module tb_block_map_walker_top import bmw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 450;
    localparam int RESET_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 60;     // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES = 4;      // two-stage pipe, plus margin
    localparam int CYCLE_LIMIT   = 300000;
    localparam int N_PHASES      = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in         in_beat   = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    t_out        out_beat;
    logic        cfg_we    = 1'b0;
    logic        cfg_idx   = CFG_LOG2;
    logic [31:0] cfg_data  = '0;

    int fail_count;
    int walk_pending;
    int results_seen;

    // idling: sender in percent (stimulus only), receiver in percent (receiver process)
    int tx_idle_pct = 13;
    int rx_idle_pct = 68;
    logic hold_req  = 1'b0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int cycles      = 0;

    // what the stimulus believes is loaded; used only to shape walks
    logic [3:0]  sh_log2 = LOG2_MIN;
    logic [31:0] sh_max  = NO_BLOCK;
    logic [31:0] sh_size = '0;

    int items;
    int n_xlate, n_resp, n_load, n_other;

    block_map_walker_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_data     (in_beat),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_data     (out_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    block_map_walker_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (walk_pending),
        .o_checked   (results_seen)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycles, walk_pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random stall at the current rate. Once the stimulus asks for it, one
    // long hold-off counted here, while the sender keeps offering beats.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic int unsigned used_log2();
        return (sh_log2 < LOG2_MIN) ? LOG2_MIN : (sh_log2 > LOG2_MAX) ? LOG2_MAX : sh_log2;
    endfunction

    // Number of response beats a translate of lbn should consume (0 = answered at once).
    function automatic int walk_depth(input logic [31:0] lbn);
        int unsigned p;
        logic [63:0] ptrs;
        logic [63:0] r;
        p = used_log2();
        ptrs = 64'd1 << p;
        if (lbn > sh_max || lbn < 12 || {32'd0, lbn} * (ptrs << 2) >= {32'd0, sh_size})
            return 0;
        r = {32'd0, lbn} - 12;
        if (r < ptrs)
            return 1;
        r = r - ptrs;
        if (r < ptrs * ptrs)
            return 2;
        r = r - ptrs * ptrs;
        return (r < ptrs * ptrs * ptrs) ? 3 : 0;
    endfunction

    // Logical block aimed at one region of the map, ends of regions favored, and
    // kept inside the file most of the time so the deeper levels really get walked.
    function automatic logic [31:0] pick_block();
        int unsigned p;
        logic [63:0] ptrs;
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] file_blocks;
        logic [63:0] v;
        p = used_log2();
        ptrs = 64'd1 << p;
        file_blocks = {32'd0, sh_size} >> (p + 2);
        case ($urandom_range(9))
            0, 1: return $urandom_range(11);
            2, 3: begin
                base = 12;
                span = ptrs;
            end
            4, 5: begin
                base = 12 + ptrs;
                span = ptrs * ptrs;
            end
            6, 7: begin
                base = 12 + ptrs + ptrs * ptrs;
                span = ptrs * ptrs * ptrs;
            end
            8: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return sh_max;
                    default: return sh_max + 1;
                endcase
            end
            default: return $urandom;
        endcase
        if (file_blocks > base && file_blocks - base < span && $urandom_range(3) != 0)
            span = file_blocks - base;
        case ($urandom_range(3))
            0: v = base;
            1: v = base + span - 1;
            default: v = base + ({$urandom, $urandom} % span);
        endcase
        return v[31:0];
    endfunction

    // Offer one beat, with random idle cycles before it, and hold it until taken.
    task automatic send_beat(input t_kind k, input logic [3:0] slot, input logic [31:0] word,
                             input logic [31:0] lbn);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{kind: k, inode_slot: slot, data_word: word, logical_block: lbn};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (k)
            KIND_LOAD: begin
                n_load++;
                items++;
                if (slot == SLOT_SIZE)
                    sh_size = word;
            end
            KIND_XLATE: begin
                n_xlate++;
                items++;
            end
            KIND_RESP: begin
                n_resp++;
                items++;
            end
            default: n_other++;
        endcase
    endtask

    // Drop valid and wait for every due result, then for the pipe to empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (walk_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers, one per cycle; junk in the unused upper bits of the log2 word.
    task automatic set_walk_config(input logic [3:0] log2_val, input logic [31:0] max_val);
        logic [31:0] log2_word;
        log2_word = $urandom;
        log2_word[3:0] = log2_val;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LOG2;
        cfg_data <= log2_word;
        @(posedge clk);
        cfg_idx  <= CFG_MAX;
        cfg_data <= max_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sh_log2 = log2_val;
        sh_max  = max_val;
    endtask

    // A translate and the responses it should need; now and then a refused
    // translate or an inode load slipped in while the walk is out.
    task automatic run_walk();
        logic [31:0] lbn;
        int depth;
        int lvl;
        lbn = pick_block();
        depth = walk_depth(lbn);
        send_beat(KIND_XLATE, 4'($urandom), $urandom, lbn);
        for (lvl = 0; lvl < depth; lvl++) begin
            if ($urandom_range(9) == 0)
                send_beat(KIND_XLATE, 4'($urandom), $urandom, pick_block());
            if ($urandom_range(9) == 0)
                send_beat(KIND_LOAD, 4'($urandom_range(11)), $urandom, $urandom);
            send_beat(KIND_RESP, 4'($urandom), $urandom, $urandom);
        end
    endtask

    // Three idling regimes over the run: slow receiver then slow sender, then
    // full rate, which is also where the long hold-off goes.
    task automatic set_idling();
        if (items < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 13;
            rx_idle_pct <= 68;
        end else if (items < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 68;
            rx_idle_pct <= 13;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
            hold_req <= 1'b1;
        end
    endtask

    initial begin
        int slot;
        int ph;
        logic [3:0]  ph_log2;
        logic [31:0] ph_max;
        logic [31:0] ph_size;
        logic [31:0] word;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // Load the whole inode first: the map memory is not cleared by reset.
        // Slot 0 holds zero and slot 1 all ones; the file size is the largest.
        for (slot = 0; slot < 16; slot++) begin
            word = (slot == 0) ? 32'd0 : (slot == 1) ? 32'hFFFF_FFFF : $urandom;
            if (slot == SLOT_SIZE)
                word = 32'hFFFF_FFFF;
            send_beat(KIND_LOAD, 4'(slot), word, (slot[0]) ? 32'hFFFF_FFFF : 32'd0);
        end
        send_beat(KIND_XLATE, 4'd0, 32'd0, 32'd0);          // first direct pointer
        send_beat(KIND_XLATE, 4'd15, 32'hFFFF_FFFF, 32'd11); // last direct pointer
        send_beat(KIND_XLATE, 4'd0, 32'd0, 32'd12);         // first single-indirect entry
        send_beat(KIND_XLATE, 4'd0, 32'd0, 32'd1);          // refused, walk still out
        send_beat(KIND_LOAD, SLOT_SINGLE, $urandom, 32'd0); // root rewritten mid-walk
        send_beat(KIND_RESP, 4'd0, $urandom, 32'd0);        // finishes the walk
        send_beat(KIND_RESP, 4'd0, $urandom, 32'd0);        // nothing out: ignored
        send_beat(KIND_NONE, 4'd0, $urandom, $urandom);     // unused kind: ignored
        // triple-indirect walk at 256 pointers per block
        send_beat(KIND_XLATE, 4'd0, 32'd0, 32'd65804 + 32'($urandom_range(1000000)));
        send_beat(KIND_RESP, 4'd0, $urandom, 32'd0);
        // pointer size changed while two levels are still to come
        settle();
        set_walk_config(4'd9, 32'hFFFF_FFFF);
        send_beat(KIND_RESP, 4'd0, $urandom, 32'd0);
        send_beat(KIND_RESP, 4'd0, $urandom, 32'd0);

        // ---- random part: one register setting per phase ----
        items = 0;
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin ph_log2 = 4'd8;  ph_max = 32'hFFFF_FFFF; end
                1: begin ph_log2 = 4'd9;  ph_max = 32'hFFFF_FFFF; end
                2: begin ph_log2 = 4'd14; ph_max = 32'hFFFF_FFFF; end
                3: begin ph_log2 = 4'd0;  ph_max = $urandom_range(70000, 300000); end
                4: begin ph_log2 = 4'd15; ph_max = 32'd0; end
                5: begin ph_log2 = 4'd8;  ph_max = 32'd300; end
                6: begin ph_log2 = 4'd11; ph_max = 32'hFFFF_FFFF; end
                default: begin ph_log2 = 4'd10; ph_max = $urandom; end
            endcase
            // empty file in the zero-limit phase, otherwise mostly the largest size
            ph_size = (ph == 4) ? 32'd0 : ($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FFFF;
            settle();
            set_walk_config(ph_log2, ph_max);
            send_beat(KIND_LOAD, SLOT_SIZE, ph_size, $urandom);
            send_beat(KIND_LOAD, 4'(SLOT_SINGLE + $urandom_range(2)), $urandom, $urandom);
            while (items < (ph + 1) * RANDOM_ITEMS / N_PHASES) begin
                set_idling();
                if ($urandom_range(4) != 0)
                    run_walk();
                else
                    send_beat(t_kind'($urandom_range(3)), 4'($urandom), $urandom,
                              pick_block());
            end
        end

        settle();
        $display("Sent %0d translate, %0d response, %0d inode load and %0d ignored beats",
                 n_xlate, n_resp, n_load, n_other);
        $display("over %0d pointer-size/limit settings; %0d result beats compared",
                 N_PHASES + 1, results_seen);
        if (fail_count == 0 && walk_pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
